// ----- design/sorted_priority_queue_top_assert.svh -----
// Assertion macros used by the top-level RTL file.
// Every check is clocked on clk and is disabled while arst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The property holds in every cycle outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_DEQ  = 2'd1,
		MODE_LIST = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_REMOVED = 3'd1,
		ST_LISTED  = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [DATA_W-1:0]   value;
		logic signed [DATA_W-1:0]   head;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int INDEX = 0
) (
	input  wire logic                                clk,
	input  wire spq_pkg::cell_ctrl_t                 ctrl,
	input  wire logic [$clog2(CAPACITY+1)-1:0]       count,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   left_entry,
	input  wire logic                                left_lt,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   right_entry,
	output logic signed [spq_pkg::DATA_W-1:0]        entry,
	output logic                                     lt
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);
	localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);

	logic signed [DATA_W-1:0] entry_q;
	logic                     occupied;

	assign occupied = MY_IDX < count;
	assign lt = occupied && (ctrl.value < entry_q);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (left_lt) begin
					entry_q <= left_entry;
				end else if (lt || MY_IDX == count) begin
					entry_q <= ctrl.value;
				end
			end
			OP_REMOVE: begin
				entry_q <= right_entry;
			end
			OP_ROTATE: begin
				if (NEXT_IDX == count) begin
					entry_q <= ctrl.head;
				end else begin
					entry_q <= right_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Min-first priority queue of signed 32-bit values, held in ascending order.
// Input channel s_*: tuser carries the mode (enqueue, dequeue, list), tdata the value.
// Output channel m_*: tuser carries the status, tdata the element, tlast marks the
// final result beat of one input beat.
// An input beat lands in a one-deep request register; it is worked on as soon as
// the output register is free or being emptied in the same cycle.
// Enqueue and dequeue each give one result beat, passed through the request and output
// registers, so one beat per cycle is sustained while the receiver keeps up.
// List gives one beat per held value (a single beat when empty): the row of cells
// rotates by one place per emitted beat and is back in order after the last one.
// A full queue drops an enqueued value and reports it; an empty one reports empty.
// Reset empties the queue and clears both handshake stages; the held values
// themselves are not cleared. When the receiver stalls, the output register holds
// its beat and one further input beat may still be accepted into the request stage.
module sorted_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [spq_pkg::DATA_W-1:0]    s_tdata,  // [31:0] value
	input  wire logic [1:0]                    s_tuser,  // [1:0] mode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [spq_pkg::DATA_W-1:0]         m_tdata,  // [31:0] element
	output logic [2:0]                         m_tuser,  // [2:0] status
	output logic                               m_tlast
);
	import spq_pkg::*;
`include "sorted_priority_queue_top_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic                     req_valid_q;
	mode_t                    req_mode_q;
	logic signed [DATA_W-1:0] req_value_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            list_pos_q;
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [DATA_W-1:0]        out_element_q;
	logic                     out_last_q;

	cell_ctrl_t               ctrl;
	logic signed [DATA_W-1:0] ent [CAPACITY];
	logic                     lt [CAPACITY];

	logic                     out_free;
	logic                     fire;
	logic                     full;
	logic                     empty;
	logic                     emit;
	logic                     release_req;
	status_t                  status_c;
	logic [DATA_W-1:0]        element_c;
	logic                     last_c;
	logic [CW-1:0]            count_nx;
	logic [CW-1:0]            pos_nx;

	assign out_free = !out_valid_q || m_tready;
	assign fire = req_valid_q && out_free;
	assign full = count_q == CAP_C;
	assign empty = count_q == '0;

	always_comb begin
		ctrl.op = OP_HOLD;
		ctrl.value = req_value_q;
		ctrl.head = ent[0];
		emit = 1'b0;
		release_req = 1'b0;
		status_c = ST_EMPTY;
		element_c = '0;
		last_c = 1'b1;
		count_nx = count_q;
		pos_nx = list_pos_q;
		if (fire) begin
			case (req_mode_q)
				MODE_ENQ: begin
					emit = 1'b1;
					release_req = 1'b1;
					if (full) begin
						status_c = ST_FULL;
					end else begin
						status_c = ST_ADDED;
						ctrl.op = OP_INSERT;
						count_nx = count_q + ONE_C;
					end
				end
				MODE_DEQ: begin
					emit = 1'b1;
					release_req = 1'b1;
					if (!empty) begin
						status_c = ST_REMOVED;
						element_c = ent[0];
						ctrl.op = OP_REMOVE;
						count_nx = count_q - ONE_C;
					end
				end
				MODE_LIST: begin
					emit = 1'b1;
					if (empty) begin
						release_req = 1'b1;
					end else begin
						status_c = ST_LISTED;
						element_c = ent[0];
						ctrl.op = OP_ROTATE;
						last_c = list_pos_q == count_q - ONE_C;
						if (last_c) begin
							release_req = 1'b1;
							pos_nx = '0;
						end else begin
							pos_nx = list_pos_q + ONE_C;
						end
					end
				end
				default: begin
					release_req = 1'b1;
				end
			endcase
		end
	end

	assign s_tready = !req_valid_q || release_req;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [DATA_W-1:0] left_entry;
			logic                     left_lt;
			logic signed [DATA_W-1:0] right_entry;
			if (gi == 0) begin : g_first
				assign left_entry = '0;
				assign left_lt = 1'b0;
			end else begin : g_mid
				assign left_entry = ent[gi-1];
				assign left_lt = lt[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_entry = ent[gi];
			end else begin : g_inner
				assign right_entry = ent[gi+1];
			end
			spq_cell #(
				.CAPACITY(CAPACITY),
				.INDEX(gi)
			) u_cell (
				.clk(clk),
				.ctrl(ctrl),
				.count(count_q),
				.left_entry(left_entry),
				.left_lt(left_lt),
				.right_entry(right_entry),
				.entry(ent[gi]),
				.lt(lt[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			count_q <= '0;
			list_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			list_pos_q <= pos_nx;
			if (s_tvalid && s_tready) begin
				req_valid_q <= 1'b1;
			end else if (release_req) begin
				req_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_mode_q <= mode_t'(s_tuser);
			req_value_q <= s_tdata;
		end
		if (emit) begin
			out_status_q <= status_c;
			out_element_q <= element_c;
			out_last_q <= last_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_element_q;
	assign m_tuser = out_status_q;
	assign m_tlast = out_last_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CAP_C, "Held count exceeds capacity.")
	`SPQ_ASSERT(a_no_insert_full, (ctrl.op != OP_INSERT) || !full, "Insert into a full row.")
	`SPQ_ASSERT_NEXT(a_remove_count, ctrl.op == OP_REMOVE, count_q == $past(count_q) - ONE_C,
		"Remove did not lower the held count by one.")
	`SPQ_ASSERT(a_list_pos, (list_pos_q == '0) || (list_pos_q < count_q),
		"List position runs past the held count.")
	`SPQ_ASSERT(a_head_sorted,
		(count_q < CW'(2)) || (list_pos_q != '0) || !(ent[1] < ent[0]),
		"Head of the row is not the smallest value.")

endmodule
`default_nettype wire
